### rtl/encoder_period_speed_filter_unit_defines.svh
// Assertion macros for the encoder period speed filter checker.
`ifndef ENCODER_PERIOD_SPEED_FILTER_UNIT_DEFINES_SVH
`define ENCODER_PERIOD_SPEED_FILTER_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define EPSF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define EPSF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/epsf_pkg.sv
// Shared types and constants of the encoder period speed filter.
package epsf_pkg;

  // Fixed register widths
  localparam int NUM_W   = 32;
  localparam int LIMIT_W = 16;
  localparam int WIN_W   = 24;
  localparam int COEF_W  = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  // Register reset values
  localparam logic [NUM_W-1:0]   RST_NUMERATOR = 32'd160849544;
  localparam logic [LIMIT_W-1:0] RST_LIMIT     = 16'd61440;
  localparam logic [WIN_W-1:0]   RST_STALL     = 24'd400000;
  localparam logic [COEF_W-1:0]  RST_FEEDBACK  = 16'd64880;
  localparam logic [COEF_W-1:0]  RST_INPUT     = 16'd328;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUMERATOR = 3'd0,
    CFG_LIMIT     = 3'd1,
    CFG_STALL     = 3'd2,
    CFG_FEEDBACK  = 3'd3,
    CFG_INPUT     = 3'd4
  } cfg_reg_e;

  // Register file contents
  typedef struct packed {
    logic [NUM_W-1:0]   numerator;
    logic [LIMIT_W-1:0] limit;
    logic [WIN_W-1:0]   stall_ticks;
    logic [COEF_W-1:0]  feedback;
    logic [COEF_W-1:0]  input_gain;
  } cfg_t;

  // Command from front to back: a period closed, and/or the window stalled
  typedef struct packed {
    logic div;
    logic stall;
  } cmd_t;

  localparam int CMD_W = $bits(cmd_t);

endpackage

### rtl/epsf_queue.sv
// Two-entry command queue between the front and back parts.
module epsf_queue import epsf_pkg::*; #(
  parameter int DATA_W = 27
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] data_i,
  output logic              full_o,
  output logic              valid_o,
  output logic [DATA_W-1:0] data_o,
  input  logic              pop_i
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### rtl/epsf_front.sv
// Front part: edge detection, period counting and stall window.
module epsf_front import epsf_pkg::*; #(
  parameter int PERIOD_BITS = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [WIN_W-1:0]     stall_ticks_i,
  input  logic                 pin_valid_i,
  input  logic                 pin_level_i,
  output logic                 pin_ready_o,
  input  logic                 queue_full_i,
  output logic                 push_o,
  output cmd_t                 cmd_o,
  output logic [PERIOD_BITS:0] period_o
);

  localparam logic [PERIOD_BITS-1:0] PERIOD_MAX = '1;

  logic                   last_level_q, last_level_d;
  logic                   armed_q, armed_d;
  logic [PERIOD_BITS-1:0] period_cnt_q, period_cnt_d;
  logic                   edge_seen_q, edge_seen_d;
  logic [WIN_W-1:0]       win_cnt_q, win_cnt_d;

  logic             accept;
  logic             pin_edge;
  logic             closing;
  logic             seen_now;
  logic [WIN_W:0]   win_inc;
  logic [WIN_W-1:0] win_len;
  logic             win_end;

  assign pin_ready_o = !queue_full_i;
  assign accept      = pin_valid_i && pin_ready_o;
  assign push_o      = accept;

  // Per-tick classification
  always_comb begin
    pin_edge = (pin_level_i != last_level_q);
    closing  = pin_edge && armed_q;
    seen_now = edge_seen_q || closing;
    win_inc  = {1'b0, win_cnt_q} + 1'b1;
    win_len  = (stall_ticks_i == '0) ? WIN_W'(1) : stall_ticks_i;
    win_end  = (win_inc >= {1'b0, win_len});

    cmd_o.div   = closing;
    cmd_o.stall = win_end && !seen_now;
    period_o    = {1'b0, period_cnt_q} + 1'b1;

    last_level_d = pin_level_i;
    armed_d      = armed_q || pin_edge;
    period_cnt_d = period_cnt_q;
    if (pin_edge) begin
      period_cnt_d = '0;
    end else if (armed_q && period_cnt_q != PERIOD_MAX) begin
      period_cnt_d = period_cnt_q + 1'b1;
    end
    if (win_end) begin
      edge_seen_d = 1'b0;
      win_cnt_d   = '0;
    end else begin
      edge_seen_d = seen_now;
      win_cnt_d   = win_inc[WIN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_level_q <= 1'b0;
      armed_q      <= 1'b0;
      period_cnt_q <= '0;
      edge_seen_q  <= 1'b0;
      win_cnt_q    <= '0;
    end else if (accept) begin
      last_level_q <= last_level_d;
      armed_q      <= armed_d;
      period_cnt_q <= period_cnt_d;
      edge_seen_q  <= edge_seen_d;
      win_cnt_q    <= win_cnt_d;
    end
  end

endmodule

### rtl/epsf_back.sv
// Back part: bit-serial divide, IIR filter and result register.
module epsf_back import epsf_pkg::*; #(
  parameter int PERIOD_BITS = 24,
  parameter int SPEED_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  cmd_valid_i,
  input  cmd_t                  cmd_i,
  input  logic [PERIOD_BITS:0]  period_i,
  output logic                  cmd_pop_o,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output logic [SPEED_BITS-1:0] speed_o,
  output logic                  sample_taken_o,
  output logic                  stalled_o
);

  localparam int DIV_W = PERIOD_BITS + 1;
  localparam int CNT_W = $clog2(NUM_W);
  localparam int PA_W  = SPEED_BITS + COEF_W;
  localparam int SUM_W = SPEED_BITS + 1;
  localparam int PB_W  = SPEED_BITS + COEF_W + 1;
  localparam int ACC_W = SPEED_BITS + COEF_W + 2;
  localparam int YF_W  = ACC_W - COEF_W;
  localparam logic [SPEED_BITS-1:0] SPEED_MAX = '1;
  localparam logic [NUM_W:0] SPEED_MAX_EXT =
    {{(NUM_W + 1 - SPEED_BITS){1'b0}}, {SPEED_BITS{1'b1}}};
  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_W - 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_FA   = 5'b00100,
    S_FB   = 5'b01000,
    S_FC   = 5'b10000
  } back_state_e;

  back_state_e state_q, state_d;

  // Divider
  logic [NUM_W-1:0] num_q, num_d;
  logic [DIV_W-1:0] rem_q, rem_d;
  logic [DIV_W-1:0] div_q, div_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             stall_q, stall_d;

  // Filter
  logic [SPEED_BITS-1:0] x_q, x_d;
  logic [PA_W-1:0]       prod_a_q, prod_a_d;
  logic [SUM_W-1:0]      sum_q, sum_d;
  logic [PB_W-1:0]       prod_b_q, prod_b_d;
  logic [SPEED_BITS-1:0] filt_y_q, filt_y_d;
  logic [SPEED_BITS-1:0] prev_x_q, prev_x_d;
  logic [SPEED_BITS-1:0] shown_q, shown_d;

  // Result register
  logic                  res_valid_q, res_valid_d;
  logic [SPEED_BITS-1:0] res_speed_q;
  logic                  res_taken_q, res_stall_q;

  logic                  out_free;
  logic                  emit;
  logic [SPEED_BITS-1:0] emit_speed;
  logic                  emit_taken;
  logic                  emit_stall;

  logic [DIV_W:0]        trial;
  logic [DIV_W:0]        diff;
  logic                  ge;
  logic [DIV_W-1:0]      rem_next;
  logic [SPEED_BITS-1:0] x_sat;
  logic                  below;
  logic [ACC_W-1:0]      acc;
  logic [YF_W-1:0]       y_full;
  logic [SPEED_BITS-1:0] y_sat;

  assign out_free       = !res_valid_q || res_ready_i;
  assign res_valid_o    = res_valid_q;
  assign speed_o        = res_speed_q;
  assign sample_taken_o = res_taken_q;
  assign stalled_o      = res_stall_q;

  // Datapath: one restoring divide step, saturation, filter sum
  always_comb begin
    trial    = {rem_q, num_q[NUM_W-1]};
    diff     = trial - {1'b0, div_q};
    ge       = (trial >= {1'b0, div_q});
    rem_next = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
    x_sat    = ({1'b0, num_q} > SPEED_MAX_EXT) ? SPEED_MAX : num_q[SPEED_BITS-1:0];
    below    = (NUM_W'(x_sat) < NUM_W'(cfg_i.limit));
    acc      = ACC_W'(prod_a_q) + ACC_W'(prod_b_q) + ROUND_HALF;
    y_full   = acc[ACC_W-1:COEF_W];
    y_sat    = (y_full > YF_W'(SPEED_MAX)) ? SPEED_MAX : y_full[SPEED_BITS-1:0];
  end

  // Sequencer
  always_comb begin
    state_d    = state_q;
    num_d      = num_q;
    rem_d      = rem_q;
    div_d      = div_q;
    cnt_d      = cnt_q;
    stall_d    = stall_q;
    x_d        = x_q;
    prod_a_d   = prod_a_q;
    sum_d      = sum_q;
    prod_b_d   = prod_b_q;
    filt_y_d   = filt_y_q;
    prev_x_d   = prev_x_q;
    shown_d    = shown_q;
    cmd_pop_o  = 1'b0;
    emit       = 1'b0;
    emit_speed = shown_q;
    emit_taken = 1'b0;
    emit_stall = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.div) begin
            cmd_pop_o = 1'b1;
            num_d     = cfg_i.numerator;
            rem_d     = '0;
            div_d     = period_i;
            cnt_d     = '0;
            stall_d   = cmd_i.stall;
            state_d   = S_DIV;
          end else if (out_free) begin
            cmd_pop_o  = 1'b1;
            emit       = 1'b1;
            emit_stall = cmd_i.stall;
            if (cmd_i.stall) begin
              shown_d = '0;
            end
            emit_speed = shown_d;
          end
        end
      end
      S_DIV: begin
        num_d = {num_q[NUM_W-2:0], ge};
        rem_d = rem_next;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          state_d = S_FA;
        end
      end
      S_FA: begin
        if (below) begin
          x_d      = x_sat;
          prod_a_d = PA_W'(cfg_i.feedback) * PA_W'(filt_y_q);
          sum_d    = SUM_W'(x_sat) + SUM_W'(prev_x_q);
          state_d  = S_FB;
        end else if (out_free) begin
          emit       = 1'b1;
          emit_stall = stall_q;
          if (stall_q) begin
            shown_d = '0;
          end
          emit_speed = shown_d;
          state_d    = S_IDLE;
        end
      end
      S_FB: begin
        prod_b_d = PB_W'(cfg_i.input_gain) * PB_W'(sum_q);
        state_d  = S_FC;
      end
      S_FC: begin
        if (out_free) begin
          filt_y_d   = y_sat;
          prev_x_d   = x_q;
          shown_d    = stall_q ? '0 : y_sat;
          emit       = 1'b1;
          emit_taken = 1'b1;
          emit_stall = stall_q;
          emit_speed = shown_d;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    res_valid_d = emit || (res_valid_q && !res_ready_i);
  end

  // Control and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
      filt_y_q    <= '0;
      prev_x_q    <= '0;
      shown_q     <= '0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      filt_y_q    <= filt_y_d;
      prev_x_q    <= prev_x_d;
      shown_q     <= shown_d;
    end
  end

  // Working registers and result payload
  always_ff @(posedge clk_i) begin
    num_q    <= num_d;
    rem_q    <= rem_d;
    div_q    <= div_d;
    cnt_q    <= cnt_d;
    stall_q  <= stall_d;
    x_q      <= x_d;
    prod_a_q <= prod_a_d;
    sum_q    <= sum_d;
    prod_b_q <= prod_b_d;
    if (emit) begin
      res_speed_q <= emit_speed;
      res_taken_q <= emit_taken;
      res_stall_q <= emit_stall;
    end
  end

endmodule

### rtl/encoder_period_speed_filter_unit.sv
// Top level of the encoder period speed filter: config registers, front, queue, back.
// A tick closing no period goes through the queue and result register; a tick that
// closes a period also takes 32 divide steps and, when it filters, 3 filter steps; a
// rejected speed skips the filter. Throughput: one tick per cycle between edges while
// results are taken; a closing edge holds the back part, the two-entry queue absorbs
// ticks meanwhile. Reset is async, active low: registers to defaults, control cleared.
module encoder_period_speed_filter_unit import epsf_pkg::*; #(
  parameter int PERIOD_BITS = 24,
  parameter int SPEED_BITS  = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  pin_valid_i,
  output logic                  pin_ready_o,
  input  logic                  pin_level_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output logic [SPEED_BITS-1:0] speed_o,
  output logic                  sample_taken_o,
  output logic                  stalled_o
);

  localparam int Q_W = CMD_W + PERIOD_BITS + 1;

  cfg_t cfg_q;

  logic                 push;
  cmd_t                 push_cmd;
  logic [PERIOD_BITS:0] push_period;
  logic                 q_full;
  logic                 q_valid;
  logic [Q_W-1:0]       q_data;
  logic                 q_pop;
  cmd_t                 pop_cmd;
  logic [PERIOD_BITS:0] pop_period;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.numerator   <= RST_NUMERATOR;
      cfg_q.limit       <= RST_LIMIT;
      cfg_q.stall_ticks <= RST_STALL;
      cfg_q.feedback    <= RST_FEEDBACK;
      cfg_q.input_gain  <= RST_INPUT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NUMERATOR: cfg_q.numerator   <= cfg_wdata_i[NUM_W-1:0];
        CFG_LIMIT:     cfg_q.limit       <= cfg_wdata_i[LIMIT_W-1:0];
        CFG_STALL:     cfg_q.stall_ticks <= cfg_wdata_i[WIN_W-1:0];
        CFG_FEEDBACK:  cfg_q.feedback    <= cfg_wdata_i[COEF_W-1:0];
        CFG_INPUT:     cfg_q.input_gain  <= cfg_wdata_i[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  epsf_front #(
    .PERIOD_BITS(PERIOD_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .stall_ticks_i(cfg_q.stall_ticks),
    .pin_valid_i  (pin_valid_i),
    .pin_level_i  (pin_level_i),
    .pin_ready_o  (pin_ready_o),
    .queue_full_i (q_full),
    .push_o       (push),
    .cmd_o        (push_cmd),
    .period_o     (push_period)
  );

  epsf_queue #(
    .DATA_W(Q_W)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i ({push_cmd, push_period}),
    .full_o (q_full),
    .valid_o(q_valid),
    .data_o (q_data),
    .pop_i  (q_pop)
  );

  assign pop_cmd    = cmd_t'(q_data[Q_W-1 -: CMD_W]);
  assign pop_period = q_data[PERIOD_BITS:0];

  epsf_back #(
    .PERIOD_BITS(PERIOD_BITS),
    .SPEED_BITS (SPEED_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .cmd_valid_i   (q_valid),
    .cmd_i         (pop_cmd),
    .period_i      (pop_period),
    .cmd_pop_o     (q_pop),
    .res_valid_o   (res_valid_o),
    .res_ready_i   (res_ready_i),
    .speed_o       (speed_o),
    .sample_taken_o(sample_taken_o),
    .stalled_o     (stalled_o)
  );

endmodule

### rtl/epsf_checker.sv
// Port-level checker for the encoder period speed filter, bound to the top level.
`include "encoder_period_speed_filter_unit_defines.svh"

module epsf_checker #(
  parameter int SPEED_BITS = 16
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  pin_valid_i,
  input logic                  pin_ready_o,
  input logic                  res_valid_o,
  input logic                  res_ready_i,
  input logic [SPEED_BITS-1:0] speed_o,
  input logic                  sample_taken_o,
  input logic                  stalled_o
);

  logic [2:0] pend_q;

  // Beats accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 3'(pin_valid_i && pin_ready_o) - 3'(res_valid_o && res_ready_i);
    end
  end

  `EPSF_ASSERT_NXT(a_res_hold, res_valid_o && !res_ready_i, res_valid_o && $stable(speed_o) && $stable(sample_taken_o) && $stable(stalled_o), "result beat changed while stalled")
  `EPSF_ASSERT_IMP(a_no_extra, res_valid_o, pend_q != 3'd0, "result beat with no tick pending")
  `EPSF_ASSERT_IMP(a_stall_zero, res_valid_o && stalled_o, speed_o == '0, "stall beat with nonzero speed")
  `EPSF_ASSERT_IMP(a_taken_excl, res_valid_o && sample_taken_o, !stalled_o, "sample and stall in one beat")

endmodule

bind encoder_period_speed_filter_unit epsf_checker #(
  .SPEED_BITS(SPEED_BITS)
) u_epsf_checker (.*);

### bench/tb_top.sv
// Testbench of the encoder period speed filter: tick stimulus, speed predictor, beat checker.
module tb_top;
  import epsf_pkg::*;

  localparam int SPEED_W = 16;
  localparam int PERIOD_W = 24;
  localparam longint unsigned SPEED_MAX = 65535;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 300;
  localparam int REPORT_CAP = 40;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  typedef struct {
    logic [SPEED_W-1:0] speed;
    logic               taken;
    logic               stall;
  } speed_beat_t;

  // Predicts the result beat of each tick and checks what comes out
  class speed_scoreboard;
    logic [NUM_W-1:0]    numerator;
    logic [LIMIT_W-1:0]  limit;
    logic [WIN_W-1:0]    stall_len;
    logic [COEF_W-1:0]   coef_a;
    logic [COEF_W-1:0]   coef_b;
    logic                last_level;
    logic                armed;
    logic [PERIOD_W-1:0] period_cnt;
    logic [SPEED_W-1:0]  x1;
    logic [SPEED_W-1:0]  y1;
    logic [SPEED_W-1:0]  shown;
    logic                active;
    logic [WIN_W:0]      win_cnt;
    speed_beat_t         speed_beats_due[$];
    int                  errors;
    int                  beat_cnt;

    function new();
      numerator  = RST_NUMERATOR;
      limit      = RST_LIMIT;
      stall_len  = RST_STALL;
      coef_a     = RST_FEEDBACK;
      coef_b     = RST_INPUT;
      last_level = 1'b0;
      armed      = 1'b0;
      period_cnt = '0;
      x1         = '0;
      y1         = '0;
      shown      = '0;
      active     = 1'b0;
      win_cnt    = '0;
      errors     = 0;
      beat_cnt   = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_NUMERATOR: numerator = val[NUM_W-1:0];
        CFG_LIMIT:     limit     = val[LIMIT_W-1:0];
        CFG_STALL:     stall_len = val[WIN_W-1:0];
        CFG_FEEDBACK:  coef_a    = val[COEF_W-1:0];
        CFG_INPUT:     coef_b    = val[COEF_W-1:0];
        default: ;
      endcase
    endfunction

    // One accepted pin sample: period timing, divide, filter, stall window
    function void note_tick(logic lvl);
      speed_beat_t        due;
      longint unsigned    period;
      longint unsigned    quo;
      longint unsigned    acc;
      longint unsigned    pair;
      logic [SPEED_W-1:0] x;
      logic [WIN_W:0]     win_len;
      due.taken = 1'b0;
      due.stall = 1'b0;
      if (lvl != last_level) begin
        if (armed) begin
          period = period_cnt;
          period = period + 1;
          quo = numerator;
          quo = quo / period;
          x = (quo > SPEED_MAX) ? SPEED_MAX[SPEED_W-1:0] : quo[SPEED_W-1:0];
          active = 1'b1;
          if (x < limit) begin
            acc = coef_a;
            acc = acc * y1;
            pair = x;
            pair = pair + x1;
            acc = (acc + pair * coef_b + 32768) >> 16;
            if (acc > SPEED_MAX) acc = SPEED_MAX;
            y1 = acc[SPEED_W-1:0];
            x1 = x;
            shown = y1;
            due.taken = 1'b1;
          end
        end
        armed = 1'b1;
        period_cnt = '0;
      end else if (armed && period_cnt != '1) begin
        period_cnt++;
      end
      last_level = lvl;

      // stall window, a zero length acts as one tick
      win_len = (stall_len == '0) ? (WIN_W + 1)'(1) : {1'b0, stall_len};
      win_cnt++;
      if (win_cnt >= win_len) begin
        if (!active) begin
          shown = '0;
          due.stall = 1'b1;
        end
        active = 1'b0;
        win_cnt = '0;
      end
      due.speed = shown;
      speed_beats_due = {speed_beats_due, due};
    endfunction

    task report(string msg);
      errors++;
      if (errors <= REPORT_CAP) $display("mismatch at beat %0d: %s", beat_cnt, msg);
    endtask

    task check_beat(logic [SPEED_W-1:0] speed, logic taken, logic stall);
      speed_beat_t due;
      beat_cnt++;
      if (speed_beats_due.size() == 0) begin
        report($sformatf("result beat with nothing due, speed %0d", speed));
        return;
      end
      due = speed_beats_due.pop_front();
      if (speed !== due.speed)
        report($sformatf("speed %0d, want %0d", speed, due.speed));
      if (taken !== due.taken)
        report($sformatf("sample_taken %b, want %b", taken, due.taken));
      if (stall !== due.stall)
        report($sformatf("stalled %b, want %b", stall, due.stall));
    endtask
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  pin_valid_i;
  logic                  pin_ready_o;
  logic                  pin_level_i;
  logic                  res_valid_o;
  logic                  res_ready_i;
  logic [SPEED_W-1:0]    speed_o;
  logic                  sample_taken_o;
  logic                  stalled_o;

  speed_scoreboard sb;
  logic            pin_now;
  int              send_idle_pct;
  int              recv_stall_pct;
  logic            hold_req;
  int              cycle_cnt = 0;

  encoder_period_speed_filter_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .pin_valid_i    (pin_valid_i),
    .pin_ready_o    (pin_ready_o),
    .pin_level_i    (pin_level_i),
    .res_valid_o    (res_valid_o),
    .res_ready_i    (res_ready_i),
    .speed_o        (speed_o),
    .sample_taken_o (sample_taken_o),
    .stalled_o      (stalled_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    res_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        res_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        res_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Check every accepted result beat
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o && res_ready_i) sb.check_beat(speed_o, sample_taken_o, stalled_o);
  end

  // One pin sample, with random gaps before it
  task automatic send_tick(input logic lvl);
    while ($urandom_range(99) < send_idle_pct) begin
      pin_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    pin_valid_i <= 1'b1;
    pin_level_i <= lvl;
    @(posedge clk_i);
    while (!pin_ready_o) @(posedge clk_i);
    sb.note_tick(lvl);
    pin_now = lvl;
  endtask

  // Fixed level sequence, MSB first
  task automatic send_levels(input logic [31:0] bits, input int n);
    for (int i = n - 1; i >= 0; i--) send_tick(bits[i]);
  endtask

  // Mostly clean square-wave periods of random length, some noise bursts
  task automatic drive_pattern(input int n_ticks);
    int sent;
    int pick;
    int run_len;
    sent = 0;
    while (sent < n_ticks) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        run_len = $urandom_range(30, 1);
      end else if (pick < 90) begin
        run_len = $urandom_range(120, 31);
      end else begin
        run_len = 0;
      end
      if (run_len == 0) begin
        repeat ($urandom_range(8, 1)) begin
          send_tick(1'($urandom_range(1)));
          sent++;
        end
      end else begin
        pin_now = ~pin_now;
        repeat (run_len) begin
          send_tick(pin_now);
          sent++;
        end
      end
    end
  endtask

  // Drop valid and wait until every result is back
  task automatic settle();
    pin_valid_i <= 1'b0;
    while (sb.speed_beats_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  task automatic apply_cfg(input cfg_t c);
    write_reg(CFG_NUMERATOR, c.numerator);
    write_reg(CFG_LIMIT, CFG_DATA_W'(c.limit));
    write_reg(CFG_STALL, CFG_DATA_W'(c.stall_ticks));
    write_reg(CFG_FEEDBACK, CFG_DATA_W'(c.feedback));
    write_reg(CFG_INPUT, CFG_DATA_W'(c.input_gain));
    cfg_we_i <= 1'b0;
  endtask

  // Register set for a random phase, extremes now and then
  function automatic cfg_t rand_cfg();
    cfg_t c;
    int   pick;
    pick = $urandom_range(99);
    if (pick < 70) c.numerator = $urandom_range(1500000, 20000);
    else if (pick < 85) c.numerator = $urandom;
    else c.numerator = $urandom_range(5000, 0);
    pick = $urandom_range(99);
    if (pick < 10) c.limit = '1;
    else if (pick < 15) c.limit = '0;
    else c.limit = LIMIT_W'($urandom_range(65535, 1000));
    pick = $urandom_range(99);
    if (pick < 70) c.stall_ticks = WIN_W'($urandom_range(80, 1));
    else if (pick < 80) c.stall_ticks = WIN_W'($urandom_range(600, 100));
    else if (pick < 90) c.stall_ticks = '1;
    else c.stall_ticks = '0;
    pick = $urandom_range(99);
    if (pick < 50) c.feedback = COEF_W'($urandom_range(65535, 50000));
    else if (pick < 80) c.feedback = COEF_W'($urandom);
    else if (pick < 90) c.feedback = '0;
    else c.feedback = '1;
    pick = $urandom_range(99);
    if (pick < 50) c.input_gain = COEF_W'($urandom_range(2000, 0));
    else if (pick < 85) c.input_gain = COEF_W'($urandom);
    else c.input_gain = '1;
    return c;
  endfunction

  initial begin
    cfg_t       c;
    idle_mode_e mode;
    rst_ni         = 1'b0;
    pin_valid_i    = 1'b0;
    pin_level_i    = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_NUMERATOR;
    cfg_wdata_i    = '0;
    pin_now        = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset registers: high first sample arms, fast edge saturates and is rejected
    send_levels(32'b11100, 5);
    settle();

    // Full-scale coefficients and limit, window of zero: filter saturates
    c = '{numerator: 32'd100000, limit: '1, stall_ticks: '0, feedback: '1, input_gain: '1};
    apply_cfg(c);
    send_levels(32'b1100111, 7);
    settle();

    // Zero limit and numerator, one-tick window: every speed dropped
    c = '{numerator: '0, limit: '0, stall_ticks: 24'd1, feedback: '0, input_gain: '0};
    apply_cfg(c);
    send_levels(32'b0110, 4);
    settle();

    // Largest numerator at the top limit, edges landing on window ends
    c = '{numerator: '1, limit: '1, stall_ticks: 24'd3, feedback: '0,
          input_gain: 16'd32768};
    apply_cfg(c);
    send_levels(32'b01010, 5);
    settle();

    // Random phases, idle pattern rotating, one long result hold-off
    for (int phase = 0; phase < 9; phase++) begin
      mode = idle_mode_e'(phase % 4);
      case (mode)
        IDLE_NONE: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        IDLE_SEND: begin
          send_idle_pct = 50;
          recv_stall_pct = 0;
        end
        IDLE_RECV: begin
          send_idle_pct = 0;
          recv_stall_pct = 50;
        end
        default: begin
          send_idle_pct = 21;
          recv_stall_pct = 21;
        end
      endcase
      apply_cfg(rand_cfg());
      if (phase == 4) hold_req = 1'b1;
      drive_pattern(95);
      settle();
    end

    repeat (40) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
